FILE: hw/rtl/ps2s2_pkg.sv
// Package for the PS/2 set 2 scan decoder: types, byte codes and key tables.
// No dependencies; used by the decode logic, the top level and the test bench.
`timescale 1ns / 1ps

package ps2s2_pkg;

    // Prefix and special scan bytes
    localparam logic [7:0] BYTE_RELEASE = 8'hF0;
    localparam logic [7:0] BYTE_EXTEND  = 8'hE0;
    localparam logic [7:0] CODE_PRTSC   = 8'h7C;
    localparam logic [7:0] CODE_LSHIFT  = 8'h12;
    localparam logic [7:0] CODE_RSHIFT  = 8'h59;
    localparam logic [7:0] CODE_CTRL    = 8'h14;
    localparam logic [7:0] CODE_ALT     = 8'h11;
    localparam logic [7:0] CODE_LSYS    = 8'h1F;
    localparam logic [7:0] CODE_RSYS    = 8'h27;
    localparam logic [7:0] CODE_CAPS    = 8'h58;
    localparam logic [7:0] CODE_NUM     = 8'h77;
    localparam logic [7:0] CODE_SCROLL  = 8'h7E;

    // Modifier and lock bit positions
    localparam int MOD_LSHIFT = 0;
    localparam int MOD_RSHIFT = 1;
    localparam int MOD_LCTRL  = 2;
    localparam int MOD_RCTRL  = 3;
    localparam int MOD_LALT   = 4;
    localparam int MOD_RALT   = 5;
    localparam int MOD_LSYS   = 6;
    localparam int MOD_RSYS   = 7;
    localparam int LOCK_CAPS   = 0;
    localparam int LOCK_NUM    = 1;
    localparam int LOCK_SCROLL = 2;

    localparam logic [2:0] LOCK_RESET = 3'b010;
    localparam logic [6:0] CASE_DELTA = 7'h20;

    // Parser position: bytes of a prefix sequence seen so far
    typedef enum logic [2:0] {
        SEQ_IDLE = 3'd0,
        SEQ_PFX1 = 3'd1,
        SEQ_PFX2 = 3'd2,
        SEQ_PFX3 = 3'd3,
        SEQ_PFX4 = 3'd4,
        SEQ_PFX5 = 3'd5
    } seq_t;

    // Translation class of a plain key
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_PLAIN  = 3'd1,
        KIND_SHIFT  = 3'd2,
        KIND_LETTER = 3'd3,
        KIND_PAD    = 3'd4,
        KIND_FIXED  = 3'd5
    } kind_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        seq_t       seq;
        logic [2:0] locks;
        logic [7:0] mods;
    } dec_state_t;

    // One key event
    typedef struct packed {
        logic [7:0] scan_code;
        logic       is_extended;
        logic       is_print_screen;
        logic       pressed;
        logic [6:0] ascii_char;
        logic [7:0] modifier_flags;
        logic [2:0] lock_flags;
        logic       seq_error;
    } result_t;

    function automatic kind_t kind_of(input logic [7:0] code);
        kind_t k;
        unique case (code)
            8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
            8'h11, 8'h12, 8'h14, 8'h58, 8'h59, 8'h76, 8'h77, 8'h78, 8'h7E, 8'h83:
                k = KIND_PLAIN;
            8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45,
            8'h0E, 8'h4E, 8'h55, 8'h5D, 8'h54, 8'h5B, 8'h4C, 8'h52, 8'h41, 8'h49,
            8'h4A:
                k = KIND_SHIFT;
            8'h15, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h21, 8'h22, 8'h23, 8'h24, 8'h2A,
            8'h2B, 8'h2C, 8'h2D, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B,
            8'h3C, 8'h42, 8'h43, 8'h44, 8'h4B, 8'h4D:
                k = KIND_LETTER;
            8'h70, 8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D,
            8'h71:
                k = KIND_PAD;
            8'h7C, 8'h7B, 8'h79, 8'h66, 8'h0D, 8'h5A, 8'h29:
                k = KIND_FIXED;
            default:
                k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Unshifted, lower case, num-lock-on or fixed character
    function automatic logic [6:0] base_char(input logic [7:0] code);
        logic [6:0] c;
        unique case (code)
            8'h16: c = 7'h31;  8'h1E: c = 7'h32;  8'h26: c = 7'h33;  8'h25: c = 7'h34;
            8'h2E: c = 7'h35;  8'h36: c = 7'h36;  8'h3D: c = 7'h37;  8'h3E: c = 7'h38;
            8'h46: c = 7'h39;  8'h45: c = 7'h30;  8'h0E: c = 7'h60;  8'h4E: c = 7'h2D;
            8'h55: c = 7'h3D;  8'h5D: c = 7'h5C;  8'h54: c = 7'h5B;  8'h5B: c = 7'h5D;
            8'h4C: c = 7'h3B;  8'h52: c = 7'h27;  8'h41: c = 7'h2C;  8'h49: c = 7'h2E;
            8'h4A: c = 7'h2F;
            8'h15: c = 7'h71;  8'h1A: c = 7'h7A;  8'h1B: c = 7'h73;  8'h1C: c = 7'h61;
            8'h1D: c = 7'h77;  8'h21: c = 7'h63;  8'h22: c = 7'h78;  8'h23: c = 7'h64;
            8'h24: c = 7'h65;  8'h2A: c = 7'h76;  8'h2B: c = 7'h66;  8'h2C: c = 7'h74;
            8'h2D: c = 7'h72;  8'h31: c = 7'h6E;  8'h32: c = 7'h62;  8'h33: c = 7'h68;
            8'h34: c = 7'h67;  8'h35: c = 7'h79;  8'h3A: c = 7'h6D;  8'h3B: c = 7'h6A;
            8'h3C: c = 7'h75;  8'h42: c = 7'h6B;  8'h43: c = 7'h69;  8'h44: c = 7'h6F;
            8'h4B: c = 7'h6C;  8'h4D: c = 7'h70;
            8'h70: c = 7'h30;  8'h69: c = 7'h31;  8'h72: c = 7'h32;  8'h7A: c = 7'h33;
            8'h6B: c = 7'h34;  8'h73: c = 7'h35;  8'h74: c = 7'h36;  8'h6C: c = 7'h37;
            8'h75: c = 7'h38;  8'h7D: c = 7'h39;  8'h71: c = 7'h2C;
            8'h7C: c = 7'h2A;  8'h7B: c = 7'h2D;  8'h79: c = 7'h2B;  8'h66: c = 7'h08;
            8'h0D: c = 7'h09;  8'h5A: c = 7'h0A;  8'h29: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted character, or num-lock-off character of a keypad key
    function automatic logic [6:0] alt_char(input logic [7:0] code);
        logic [6:0] c;
        unique case (code)
            8'h16: c = 7'h21;  8'h1E: c = 7'h40;  8'h26: c = 7'h23;  8'h25: c = 7'h24;
            8'h2E: c = 7'h25;  8'h36: c = 7'h5E;  8'h3D: c = 7'h26;  8'h3E: c = 7'h2A;
            8'h46: c = 7'h28;  8'h45: c = 7'h29;  8'h0E: c = 7'h7E;  8'h4E: c = 7'h5F;
            8'h55: c = 7'h2B;  8'h5D: c = 7'h7C;  8'h54: c = 7'h7B;  8'h5B: c = 7'h7D;
            8'h4C: c = 7'h3A;  8'h52: c = 7'h22;  8'h41: c = 7'h3C;  8'h49: c = 7'h3E;
            8'h4A: c = 7'h3F;  8'h71: c = 7'h7F;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Extended (E0) keys that exist
    function automatic logic ext_known(input logic [7:0] code);
        logic k;
        unique case (code)
            8'h11, 8'h14, 8'h1F, 8'h27, 8'h2F, 8'h69, 8'h6B, 8'h6C, 8'h70, 8'h72,
            8'h74, 8'h75, 8'h7A, 8'h7D, 8'h4A, 8'h5A, 8'h71:
                k = 1'b1;
            default:
                k = 1'b0;
        endcase
        return k;
    endfunction

    // Fixed character of an extended key
    function automatic logic [6:0] ext_char(input logic [7:0] code);
        logic [6:0] c;
        unique case (code)
            8'h4A:   c = 7'h2F;
            8'h5A:   c = 7'h0A;
            8'h71:   c = 7'h7F;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/ps2s2_if.sv
// Handshake channels of the PS/2 set 2 scan decoder: byte input and key event output.
// No dependencies.
`timescale 1ns / 1ps

interface ps2s2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s2_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;
    logic       is_extended;
    logic       is_print_screen;
    logic       pressed;
    logic [6:0] ascii_char;
    logic [7:0] modifier_flags;
    logic [2:0] lock_flags;
    logic       seq_error;

    modport source (output valid, output scan_code, output is_extended,
                     output is_print_screen, output pressed, output ascii_char,
                     output modifier_flags, output lock_flags, output seq_error,
                     input ready);
    modport sink   (input valid, input scan_code, input is_extended,
                     input is_print_screen, input pressed, input ascii_char,
                     input modifier_flags, input lock_flags, input seq_error,
                     output ready);
endinterface

FILE: hw/rtl/ps2s2_decode.sv
// Combinational decode of one scan byte: prefix parser, lock/modifier update and
// ASCII translation. Depends on ps2s2_pkg.
`timescale 1ns / 1ps

module ps2s2_decode
    import ps2s2_pkg::*;
(
    input  dec_state_t cur,
    input  logic [7:0] pfx0,
    input  logic [7:0] pfx1,
    input  logic [7:0] pfx2,
    input  logic [7:0] scan_byte,
    output dec_state_t nxt,
    output logic [2:0] pfx_we,
    output logic       emit,
    output result_t    res
);

    seq_t       seq_next;
    logic       fin;
    logic       bad;
    logic       f_rel;
    logic       f_ext;
    logic       f_ps;
    kind_t      kind;
    logic [2:0] locks_next;
    logic [7:0] mods_next;
    logic [7:0] mod_mask;
    logic       shift;

    assign kind = kind_of(scan_byte);

    // Prefix parser: next position and what the byte completes
    always_comb
    begin
        seq_next = SEQ_IDLE;
        pfx_we   = '0;
        fin      = 1'b0;
        bad      = 1'b0;
        f_rel    = 1'b0;
        f_ext    = 1'b0;
        f_ps     = 1'b0;
        unique case (cur.seq)
            SEQ_IDLE:
            begin
                if (scan_byte == BYTE_RELEASE || scan_byte == BYTE_EXTEND)
                begin
                    pfx_we[0] = 1'b1;
                    seq_next  = SEQ_PFX1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            SEQ_PFX1:
            begin
                if (pfx0 == BYTE_RELEASE)
                begin
                    fin   = 1'b1;
                    f_rel = 1'b1;
                end
                else if (scan_byte == BYTE_RELEASE || scan_byte == CODE_LSHIFT)
                begin
                    pfx_we[1] = 1'b1;
                    seq_next  = SEQ_PFX2;
                end
                else
                begin
                    fin   = 1'b1;
                    f_ext = 1'b1;
                end
            end
            SEQ_PFX2:
            begin
                if (pfx1 == BYTE_RELEASE)
                begin
                    if (scan_byte == CODE_PRTSC)
                    begin
                        pfx_we[2] = 1'b1;
                        seq_next  = SEQ_PFX3;
                    end
                    else
                    begin
                        fin   = 1'b1;
                        f_rel = 1'b1;
                        f_ext = 1'b1;
                    end
                end
                else if (scan_byte == BYTE_EXTEND)
                begin
                    pfx_we[2] = 1'b1;
                    seq_next  = SEQ_PFX3;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            SEQ_PFX3:
            begin
                if (pfx1 == BYTE_RELEASE && pfx2 == CODE_PRTSC && scan_byte == BYTE_EXTEND)
                begin
                    seq_next = SEQ_PFX4;
                end
                else if (pfx1 == CODE_LSHIFT && pfx2 == BYTE_EXTEND
                         && scan_byte == CODE_PRTSC)
                begin
                    fin  = 1'b1;
                    f_ps = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            SEQ_PFX4:
            begin
                if (scan_byte == BYTE_RELEASE)
                    seq_next = SEQ_PFX5;
                else
                    bad = 1'b1;
            end
            SEQ_PFX5:
            begin
                if (scan_byte == CODE_LSHIFT)
                begin
                    fin   = 1'b1;
                    f_ps  = 1'b1;
                    f_rel = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // Key completion: flag update, translation and result fields
    always_comb
    begin
        locks_next = cur.locks;
        mods_next  = cur.mods;
        mod_mask   = '0;
        shift      = 1'b0;

        res.scan_code       = scan_byte;
        res.is_extended     = f_ext;
        res.is_print_screen = 1'b0;
        res.pressed         = !f_rel;
        res.ascii_char      = '0;
        res.seq_error       = 1'b0;

        if (bad)
        begin
            res.is_extended = 1'b0;
            res.pressed     = 1'b0;
            res.seq_error   = 1'b1;
        end
        else if (fin && f_ps)
        begin
            res.scan_code       = '0;
            res.is_extended     = 1'b0;
            res.is_print_screen = 1'b1;
        end
        else if (fin && f_ext)
        begin
            if (!ext_known(scan_byte))
            begin
                res.seq_error = 1'b1;
            end
            else
            begin
                res.ascii_char = ext_char(scan_byte);
                if (scan_byte == CODE_CTRL)
                    mod_mask[MOD_RCTRL] = 1'b1;
                else if (scan_byte == CODE_ALT)
                    mod_mask[MOD_RALT] = 1'b1;
                else if (scan_byte == CODE_LSYS)
                    mod_mask[MOD_LSYS] = 1'b1;
                else if (scan_byte == CODE_RSYS)
                    mod_mask[MOD_RSYS] = 1'b1;
            end
        end
        else if (fin)
        begin
            if (kind == KIND_NONE)
            begin
                res.seq_error = 1'b1;
            end
            else
            begin
                priority if (!f_rel && scan_byte == CODE_CAPS)
                    locks_next[LOCK_CAPS] = !cur.locks[LOCK_CAPS];
                else if (!f_rel && scan_byte == CODE_NUM)
                    locks_next[LOCK_NUM] = !cur.locks[LOCK_NUM];
                else if (!f_rel && scan_byte == CODE_SCROLL)
                    locks_next[LOCK_SCROLL] = !cur.locks[LOCK_SCROLL];
                else if (scan_byte == CODE_LSHIFT)
                    mod_mask[MOD_LSHIFT] = 1'b1;
                else if (scan_byte == CODE_RSHIFT)
                    mod_mask[MOD_RSHIFT] = 1'b1;
                else if (scan_byte == CODE_CTRL)
                    mod_mask[MOD_LCTRL] = 1'b1;
                else if (scan_byte == CODE_ALT)
                    mod_mask[MOD_LALT] = 1'b1;
                else
                    mod_mask = '0;
            end
        end

        // modifier press sets, release clears
        if (f_rel)
            mods_next = cur.mods & ~mod_mask;
        else
            mods_next = cur.mods | mod_mask;

        // plain key translation uses the updated flags
        shift = mods_next[MOD_LSHIFT] | mods_next[MOD_RSHIFT];
        if (fin && !f_ps && !f_ext)
        begin
            unique case (kind)
                KIND_SHIFT:
                    res.ascii_char = shift ? alt_char(scan_byte) : base_char(scan_byte);
                KIND_LETTER:
                    res.ascii_char = (shift != locks_next[LOCK_CAPS])
                        ? (base_char(scan_byte) - CASE_DELTA) : base_char(scan_byte);
                KIND_PAD:
                    res.ascii_char = locks_next[LOCK_NUM]
                        ? base_char(scan_byte) : alt_char(scan_byte);
                KIND_FIXED:
                    res.ascii_char = base_char(scan_byte);
                default:
                    res.ascii_char = '0;
            endcase
        end

        res.modifier_flags = mods_next;
        res.lock_flags     = locks_next;
    end

    assign nxt.seq   = seq_next;
    assign nxt.locks = locks_next;
    assign nxt.mods  = mods_next;
    assign emit      = fin | bad;

endmodule

FILE: hw/rtl/ps2_set2_scan_decoder.sv
// Top level of the PS/2 scan code set 2 decoder: input register, decoder state,
// prefix store and result register. Depends on ps2s2_pkg, ps2s2_if, ps2s2_decode.
`timescale 1ns / 1ps
//
//  Channel   Modport  Payload                                     Transaction
//  scan_ch   sink     scan_byte                                   one keyboard byte
//  key_ch    source   scan_code, is_extended, is_print_screen,    one key event or
//                     pressed, ascii_char, modifier_flags,        sequence error
//                     lock_flags, seq_error
//
//  One byte per cycle is taken unless a held result stalls it; a key event's last
//  byte passes the input register, then the decode, into the result register.
//  Reset: parser idle, num lock on, other locks and all modifiers off.
//  A held result stalls only bytes that complete a key or break a sequence; prefix bytes still pass.

module ps2_set2_scan_decoder
    import ps2s2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ps2s2_byte_if.sink   scan_ch,
    ps2s2_key_if.source  key_ch
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    dec_state_t state_reg;
    logic [7:0] pfx_reg [3];
    logic       out_valid_reg;
    result_t    out_res_reg;

    dec_state_t state_next;
    logic [2:0] pfx_we;
    logic       emit;
    result_t    res;
    logic       out_free;
    logic       advance;

    ps2s2_decode u_decode (
        .cur       (state_reg),
        .pfx0      (pfx_reg[0]),
        .pfx1      (pfx_reg[1]),
        .pfx2      (pfx_reg[2]),
        .scan_byte (in_byte_reg),
        .nxt       (state_next),
        .pfx_we    (pfx_we),
        .emit      (emit),
        .res       (res)
    );

    // Flow control: a byte leaves the input register once its result, if any, has a slot
    assign out_free      = !out_valid_reg || key_ch.ready;
    assign advance       = in_valid_reg && (!emit || out_free);
    assign scan_ch.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (scan_ch.ready)
            in_valid_reg <= scan_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan_ch.valid && scan_ch.ready)
            in_byte_reg <= scan_ch.scan_byte;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq   <= SEQ_IDLE;
            state_reg.locks <= LOCK_RESET;
            state_reg.mods  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Prefix bytes of the sequence in progress
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (advance && pfx_we[i])
                pfx_reg[i] <= in_byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (key_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_res_reg <= res;
    end

    assign key_ch.valid           = out_valid_reg;
    assign key_ch.scan_code       = out_res_reg.scan_code;
    assign key_ch.is_extended     = out_res_reg.is_extended;
    assign key_ch.is_print_screen = out_res_reg.is_print_screen;
    assign key_ch.pressed         = out_res_reg.pressed;
    assign key_ch.ascii_char      = out_res_reg.ascii_char;
    assign key_ch.modifier_flags  = out_res_reg.modifier_flags;
    assign key_ch.lock_flags      = out_res_reg.lock_flags;
    assign key_ch.seq_error       = out_res_reg.seq_error;

endmodule

FILE: hw/rtl/ps2s2_checker.sv
// Port-level checks of the PS/2 set 2 scan decoder, bound to its top level.
// Depends on ps2_set2_scan_decoder and its interface ports.
`timescale 1ns / 1ps

module ps2s2_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] scan_code,
    input logic       is_extended,
    input logic       is_print_screen,
    input logic [6:0] ascii_char,
    input logic [7:0] modifier_flags,
    input logic [2:0] lock_flags,
    input logic       seq_error
);

    // A stalled event holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scan_code)
            && $stable(ascii_char) && $stable(modifier_flags) && $stable(lock_flags))
        else $error("key event changed while stalled");

    // Print screen carries no scan code, no extended mark and no error
    a_prtsc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_print_screen |-> scan_code == 8'h00 && !is_extended && !seq_error)
        else $error("malformed print screen event");

    // An error event never carries a character
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seq_error |-> ascii_char == 7'h00 && !is_print_screen)
        else $error("error event with character");

    // Extended keys translate only to slash, newline or delete
    a_ext: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_extended && ascii_char != 7'h00
            |-> ascii_char == 7'h2F || ascii_char == 7'h0A || ascii_char == 7'h7F)
        else $error("bad character for extended key");

endmodule

bind ps2_set2_scan_decoder ps2s2_checker u_ps2s2_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (key_ch.valid),
    .out_ready       (key_ch.ready),
    .scan_code       (key_ch.scan_code),
    .is_extended     (key_ch.is_extended),
    .is_print_screen (key_ch.is_print_screen),
    .ascii_char      (key_ch.ascii_char),
    .modifier_flags  (key_ch.modifier_flags),
    .lock_flags      (key_ch.lock_flags),
    .seq_error       (key_ch.seq_error)
);

FILE: test/ps2s2_key_checker.sv
// Checker for the PS/2 set 2 scan decoder: tracks the byte and key event channels,
// predicts each key event and compares it. Depends on ps2s2_pkg and ps2s2_if.
`timescale 1ns / 1ps

module ps2s2_key_checker
    import ps2s2_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ps2s2_byte_if   scan_mon,
    ps2s2_key_if    key_mon,
    output int      mismatch_count,
    output int      events_pending
);

    // Key lists used to build the lookup arrays
    localparam logic [7:0] PLAIN_CODES [20] = '{
        8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
        8'h11, 8'h12, 8'h14, 8'h58, 8'h59, 8'h76, 8'h77, 8'h78, 8'h7E, 8'h83};
    localparam logic [7:0] SHIFT_CODES [21] = '{
        8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45,
        8'h0E, 8'h4E, 8'h55, 8'h5D, 8'h54, 8'h5B, 8'h4C, 8'h52, 8'h41, 8'h49, 8'h4A};
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h15, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h21, 8'h22, 8'h23, 8'h24, 8'h2A,
        8'h2B, 8'h2C, 8'h2D, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B,
        8'h3C, 8'h42, 8'h43, 8'h44, 8'h4B, 8'h4D};
    localparam logic [7:0] PAD_CODES [11] = '{
        8'h70, 8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D, 8'h71};
    localparam logic [7:0] FIXED_CODES [7] = '{
        8'h7C, 8'h7B, 8'h79, 8'h66, 8'h0D, 8'h5A, 8'h29};
    localparam logic [6:0] FIXED_CHARS [7] = '{
        7'h2A, 7'h2D, 7'h2B, 7'h08, 7'h09, 7'h0A, 7'h20};
    localparam logic [7:0] EXT_CODES [17] = '{
        8'h11, 8'h14, 8'h1F, 8'h27, 8'h2F, 8'h69, 8'h6B, 8'h6C, 8'h70, 8'h72,
        8'h74, 8'h75, 8'h7A, 8'h7D, 8'h4A, 8'h5A, 8'h71};

    kind_t      key_kind  [256];
    logic [6:0] key_base  [256];
    logic [6:0] key_alt   [256];
    logic       ext_valid [256];
    logic [6:0] ext_ascii [256];

    // Predicted decoder state
    seq_t       seq;
    logic [7:0] pfx [5];
    logic [2:0] locks;
    logic [7:0] mods;

    result_t    key_expect_q [$];

    // Build the translation arrays
    initial
    begin
        string shift_lo;
        string shift_hi;
        string letters;
        string pad_chars;
        shift_lo  = "1234567890`-=\\[];',./";
        shift_hi  = "!@#$%^&*()~_+|{}:\"<>?";
        letters   = "qzsawcxdevftrnbhgymjukiolp";
        pad_chars = "0123456789,";
        for (int i = 0; i < 256; i++)
        begin
            key_kind[i]  = KIND_NONE;
            key_base[i]  = '0;
            key_alt[i]   = '0;
            ext_valid[i] = 1'b0;
            ext_ascii[i] = '0;
        end
        foreach (PLAIN_CODES[i])
            key_kind[PLAIN_CODES[i]] = KIND_PLAIN;
        foreach (SHIFT_CODES[i])
        begin
            key_kind[SHIFT_CODES[i]] = KIND_SHIFT;
            key_base[SHIFT_CODES[i]] = 7'(shift_lo[i]);
            key_alt[SHIFT_CODES[i]]  = 7'(shift_hi[i]);
        end
        foreach (LETTER_CODES[i])
        begin
            key_kind[LETTER_CODES[i]] = KIND_LETTER;
            key_base[LETTER_CODES[i]] = 7'(letters[i]);
        end
        foreach (PAD_CODES[i])
        begin
            key_kind[PAD_CODES[i]] = KIND_PAD;
            key_base[PAD_CODES[i]] = 7'(pad_chars[i]);
        end
        key_alt[8'h71] = 7'h7F;     // keypad delete with num lock off
        foreach (FIXED_CODES[i])
        begin
            key_kind[FIXED_CODES[i]] = KIND_FIXED;
            key_base[FIXED_CODES[i]] = FIXED_CHARS[i];
        end
        foreach (EXT_CODES[i])
            ext_valid[EXT_CODES[i]] = 1'b1;
        ext_ascii[8'h4A] = 7'h2F;   // keypad slash
        ext_ascii[8'h5A] = 7'h0A;   // keypad enter
        ext_ascii[8'h71] = 7'h7F;   // delete
    end

    // Completed key: update flags, translate, queue the event
    task automatic finish_key(input logic [7:0] code, input bit rel, input bit ext,
                              input bit ps);
        result_t r;
        int      mbit;
        bit      shift_held;
        kind_t   k;
        r    = '0;
        mbit = -1;
        k    = KIND_NONE;
        seq  = SEQ_IDLE;
        r.pressed = !rel;
        if (ps)
        begin
            r.is_print_screen = 1'b1;
        end
        else if (ext)
        begin
            r.scan_code   = code;
            r.is_extended = 1'b1;
            if (!ext_valid[code])
                r.seq_error = 1'b1;
            else
            begin
                if (code == CODE_CTRL)
                    mbit = MOD_RCTRL;
                else if (code == CODE_ALT)
                    mbit = MOD_RALT;
                else if (code == CODE_LSYS)
                    mbit = MOD_LSYS;
                else if (code == CODE_RSYS)
                    mbit = MOD_RSYS;
                r.ascii_char = ext_ascii[code];
            end
        end
        else
        begin
            r.scan_code = code;
            k = key_kind[code];
            if (k == KIND_NONE)
                r.seq_error = 1'b1;
            else if (!rel && code == CODE_CAPS)
                locks[LOCK_CAPS] = ~locks[LOCK_CAPS];
            else if (!rel && code == CODE_NUM)
                locks[LOCK_NUM] = ~locks[LOCK_NUM];
            else if (!rel && code == CODE_SCROLL)
                locks[LOCK_SCROLL] = ~locks[LOCK_SCROLL];
            else if (code == CODE_LSHIFT)
                mbit = MOD_LSHIFT;
            else if (code == CODE_RSHIFT)
                mbit = MOD_RSHIFT;
            else if (code == CODE_CTRL)
                mbit = MOD_LCTRL;
            else if (code == CODE_ALT)
                mbit = MOD_LALT;
        end
        if (mbit >= 0)
            mods[mbit] = !rel;
        // Translation of plain keys uses the updated flags
        if (!ps && !ext && !r.seq_error)
        begin
            shift_held = mods[MOD_LSHIFT] || mods[MOD_RSHIFT];
            case (k)
                KIND_SHIFT:  r.ascii_char = shift_held ? key_alt[code] : key_base[code];
                KIND_LETTER: r.ascii_char = (shift_held != locks[LOCK_CAPS]) ?
                                            key_base[code] - CASE_DELTA : key_base[code];
                KIND_PAD:    r.ascii_char = locks[LOCK_NUM] ? key_base[code] : key_alt[code];
                KIND_FIXED:  r.ascii_char = key_base[code];
                default:     r.ascii_char = '0;
            endcase
        end
        r.modifier_flags = mods;
        r.lock_flags     = locks;
        key_expect_q.push_back(r);
    endtask

    // Broken sequence: error event, parser back to idle
    task automatic broken_sequence(input logic [7:0] b);
        result_t r;
        r                = '0;
        r.scan_code      = b;
        r.seq_error      = 1'b1;
        r.modifier_flags = mods;
        r.lock_flags     = locks;
        seq = SEQ_IDLE;
        key_expect_q.push_back(r);
    endtask

    // Sequence parser, one accepted byte
    task automatic take_byte(input logic [7:0] b);
        case (seq)
            SEQ_IDLE:
                if (b == BYTE_RELEASE || b == BYTE_EXTEND)
                begin
                    pfx[0] = b;
                    seq    = SEQ_PFX1;
                end
                else
                    finish_key(b, 1'b0, 1'b0, 1'b0);
            SEQ_PFX1:
                if (pfx[0] == BYTE_RELEASE)
                    finish_key(b, 1'b1, 1'b0, 1'b0);
                else if (b == BYTE_RELEASE || b == CODE_LSHIFT)
                begin
                    pfx[1] = b;
                    seq    = SEQ_PFX2;
                end
                else
                    finish_key(b, 1'b0, 1'b1, 1'b0);
            SEQ_PFX2:
                if (pfx[1] == BYTE_RELEASE)
                begin
                    if (b == CODE_PRTSC)
                    begin
                        pfx[2] = b;
                        seq    = SEQ_PFX3;
                    end
                    else
                        finish_key(b, 1'b1, 1'b1, 1'b0);
                end
                else if (b == BYTE_EXTEND)
                begin
                    pfx[2] = b;
                    seq    = SEQ_PFX3;
                end
                else
                    broken_sequence(b);
            SEQ_PFX3:
                if (pfx[1] == BYTE_RELEASE && pfx[2] == CODE_PRTSC && b == BYTE_EXTEND)
                begin
                    pfx[3] = b;
                    seq    = SEQ_PFX4;
                end
                else if (pfx[1] == CODE_LSHIFT && pfx[2] == BYTE_EXTEND && b == CODE_PRTSC)
                    finish_key(8'h00, 1'b0, 1'b0, 1'b1);
                else
                    broken_sequence(b);
            SEQ_PFX4:
                if (b == BYTE_RELEASE)
                begin
                    pfx[4] = b;
                    seq    = SEQ_PFX5;
                end
                else
                    broken_sequence(b);
            SEQ_PFX5:
                if (b == CODE_LSHIFT)
                    finish_key(8'h00, 1'b1, 1'b0, 1'b1);
                else
                    broken_sequence(b);
            default:
                broken_sequence(b);
        endcase
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Compare one key event transaction with the oldest prediction
    task automatic compare_event();
        result_t want;
        if (key_expect_q.size() == 0)
        begin
            $display("%0t: unexpected key event, expected none, actual scan_code 0x%0h",
                     $time, key_mon.scan_code);
            mismatch_count++;
        end
        else
        begin
            want = key_expect_q.pop_front();
            check_field("scan_code", want.scan_code, key_mon.scan_code);
            check_field("is_extended", 8'(want.is_extended), 8'(key_mon.is_extended));
            check_field("is_print_screen", 8'(want.is_print_screen),
                        8'(key_mon.is_print_screen));
            check_field("pressed", 8'(want.pressed), 8'(key_mon.pressed));
            check_field("ascii_char", 8'(want.ascii_char), 8'(key_mon.ascii_char));
            check_field("modifier_flags", want.modifier_flags, key_mon.modifier_flags);
            check_field("lock_flags", 8'(want.lock_flags), 8'(key_mon.lock_flags));
            check_field("seq_error", 8'(want.seq_error), 8'(key_mon.seq_error));
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq            = SEQ_IDLE;
            locks          = LOCK_RESET;
            mods           = '0;
            mismatch_count = 0;
            for (int i = 0; i < 5; i++)
                pfx[i] = '0;
            key_expect_q.delete();
        end
        else
        begin
            if (key_mon.valid && key_mon.ready)
                compare_event();
            if (scan_mon.valid && scan_mon.ready)
                take_byte(scan_mon.scan_byte);
        end
        events_pending = key_expect_q.size();
    end

endmodule

FILE: test/tb_ps2_set2_scan_decoder.sv
// Testbench top for the PS/2 set 2 scan decoder: clock, reset, byte stimulus,
// result back-pressure and verdict. Depends on ps2s2_pkg, ps2s2_if, ps2s2_key_checker.
`timescale 1ns / 1ps

module tb_ps2_set2_scan_decoder;
    import ps2s2_pkg::*;

    localparam int RANDOM_BYTES = 850;

    // Frequently exercised plain keys: modifiers, locks, letters, keypad, symbols
    localparam logic [7:0] HOT_PLAIN [14] = '{
        8'h12, 8'h59, 8'h14, 8'h11, 8'h58, 8'h77, 8'h7E,
        8'h1C, 8'h4D, 8'h16, 8'h5D, 8'h70, 8'h71, 8'h5A};
    localparam logic [7:0] HOT_EXT [9] = '{
        8'h14, 8'h11, 8'h1F, 8'h27, 8'h4A, 8'h5A, 8'h71, 8'h70, 8'h2F};
    localparam logic [7:0] PRTSC_MAKE [4]  = '{8'hE0, 8'h12, 8'hE0, 8'h7C};
    localparam logic [7:0] PRTSC_BREAK [6] = '{8'hE0, 8'hF0, 8'h7C, 8'hE0, 8'hF0, 8'h12};

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   events_pending;
    int   bytes_sent;
    bit   gaps_on;

    ps2s2_byte_if scan_ch ();
    ps2s2_key_if  key_ch ();

    ps2_set2_scan_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_ch (scan_ch),
        .key_ch  (key_ch)
    );

    ps2s2_key_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan_mon       (scan_ch),
        .key_mon        (key_ch),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall limit on the run
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Key event back-pressure: runs of ready, short stalls and a few long ones
    initial
    begin
        int hold;
        int r;
        hold = 0;
        key_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    key_ch.ready <= 1'b1;
                    hold = $urandom_range(0, 20);
                end
                else if (r < 92)
                begin
                    key_ch.ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    key_ch.ready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One byte transaction; valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_ch.valid     <= 1'b1;
        scan_ch.scan_byte <= b;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] code, input bit rel);
        if (rel)
            send_byte(BYTE_RELEASE);
        send_byte(code);
    endtask

    task automatic send_ext(input logic [7:0] code, input bit rel);
        send_byte(BYTE_EXTEND);
        if (rel)
            send_byte(BYTE_RELEASE);
        send_byte(code);
    endtask

    task automatic send_prtsc(input bit rel);
        if (rel)
            foreach (PRTSC_BREAK[i])
                send_byte(PRTSC_BREAK[i]);
        else
            foreach (PRTSC_MAKE[i])
                send_byte(PRTSC_MAKE[i]);
    endtask

    // Print screen sequence cut short by a random byte
    task automatic send_broken_prtsc(input bit rel);
        int n;
        n = rel ? $urandom_range(1, 5) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            send_byte(rel ? PRTSC_BREAK[i] : PRTSC_MAKE[i]);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int  r;
        int  drain;
        bit  rel;
        bytes_sent        = 0;
        gaps_on           = 1'b0;
        rst_n             <= 1'b0;
        scan_ch.valid     <= 1'b0;
        scan_ch.scan_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, shift and caps, extended keys, print screen,
        // unknown codes and a broken print screen press
        send_plain(8'h00, 1'b0);
        send_plain(8'hFF, 1'b0);
        send_plain(CODE_LSHIFT, 1'b0);
        send_plain(8'h1C, 1'b0);
        send_plain(CODE_LSHIFT, 1'b1);
        send_plain(CODE_CAPS, 1'b0);
        send_ext(CODE_CTRL, 1'b0);
        send_ext(CODE_CTRL, 1'b1);
        send_prtsc(1'b0);
        send_prtsc(1'b1);
        send_byte(BYTE_EXTEND);
        send_byte(CODE_LSHIFT);
        send_byte(8'h55);

        // Random: mostly well-formed key sequences, some broken ones and noise
        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                gaps_on = !gaps_on;
            r   = $urandom_range(0, 99);
            rel = ($urandom_range(0, 2) == 0);
            if (r < 35)
                send_plain(8'($urandom_range(0, 8'h83)), rel);
            else if (r < 60)
                send_plain(HOT_PLAIN[$urandom_range(0, 13)], rel);
            else if (r < 80)
                send_ext(($urandom_range(0, 9) < 7) ? HOT_EXT[$urandom_range(0, 8)]
                                                    : 8'($urandom_range(0, 255)), rel);
            else if (r < 86)
                send_prtsc(rel);
            else if (r < 91)
                send_broken_prtsc(rel);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        scan_ch.valid <= 1'b0;

        // Drain the remaining key events, then allow for the pipeline latency;
        // counts are read at the falling edge, after the checker has updated them
        @(negedge clk);
        drain = 0;
        while (events_pending != 0 && drain < 5000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (8) @(negedge clk);
        if (events_pending != 0)
            $display("%0t: %0d key events never arrived", $time, events_pending);
        if (mismatch_count == 0 && events_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
